// ===== src/mrp_pkg.sv =====
// Shared types and constants for the MIPS relocation patcher.
// Used by every module of the block; depends on nothing.
package mrp_pkg;

  localparam int unsigned DEFAULT_PENDING_DEPTH = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_WORD32 = 3'd1,
    KIND_JUMP26 = 3'd2,
    KIND_HI16   = 3'd3,
    KIND_LO16   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNDEF   = 2'd1,
    ST_REJECT  = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_EMIT = 2'd0,
    OP_HI   = 2'd1,
    OP_LO   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LO_RD,
    BK_LO_EX,
    BK_LO_FIN
  } back_state_e;

  // For OP_EMIT, place holds the write address and word the write data.
  typedef struct packed {
    op_e         op;
    logic        wv;
    status_e     status;
    logic [31:0] sym;
    logic [31:0] place;
    logic [31:0] word;
  } cmd_t;

  typedef struct packed {
    logic [31:0] sym;
    logic [31:0] place;
    logic [31:0] word;
  } pend_t;

endpackage

// ===== src/mrp_front.sv =====
// Front end: accepts relocations and classifies them into commands.
// Depends on mrp_pkg; feeds mrp_queue.
module mrp_front
  import mrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  relocation_kind_i,
  input  logic        symbol_defined_i,
  input  logic [31:0] symbol_value_i,
  input  logic [31:0] place_address_i,
  input  logic [31:0] place_word_i,
  output logic        cmd_valid_o,
  input  logic        cmd_full_i,
  output cmd_t        cmd_o
);

  logic        fv_q, fv_d;
  cmd_t        cmd_q, cmd_d;
  logic        accept;
  logic [31:0] place_p4;
  logic        jump_bad;

  assign in_stall_o  = fv_q && cmd_full_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cmd_valid_o = fv_q;
  assign cmd_o       = cmd_q;

  assign place_p4 = place_address_i + 32'd4;
  assign jump_bad = (symbol_value_i[1:0] != 2'b00) ||
                    (symbol_value_i[31:28] != place_p4[31:28]);

  always_comb begin
    cmd_d        = '0;
    cmd_d.op     = OP_EMIT;
    cmd_d.status = ST_OK;
    cmd_d.sym    = symbol_value_i;
    unique case (kind_e'(relocation_kind_i)) inside
      KIND_NONE: begin
        cmd_d.status = ST_OK;
      end
      KIND_WORD32: begin
        if (symbol_defined_i) begin
          cmd_d.wv    = 1'b1;
          cmd_d.place = place_address_i;
          cmd_d.word  = place_word_i + symbol_value_i;
        end else begin
          cmd_d.status = ST_UNDEF;
        end
      end
      KIND_JUMP26: begin
        if (!symbol_defined_i) begin
          cmd_d.status = ST_UNDEF;
        end else if (jump_bad) begin
          cmd_d.status = ST_REJECT;
        end else begin
          cmd_d.wv    = 1'b1;
          cmd_d.place = place_address_i;
          cmd_d.word  = {place_word_i[31:26], symbol_value_i[27:2]};
        end
      end
      KIND_HI16, KIND_LO16: begin
        if (symbol_defined_i) begin
          cmd_d.op    = (kind_e'(relocation_kind_i) == KIND_HI16) ? OP_HI : OP_LO;
          cmd_d.place = place_address_i;
          cmd_d.word  = place_word_i;
        end else begin
          cmd_d.status = ST_UNDEF;
        end
      end
      default: begin
        cmd_d.status = ST_UNKNOWN;
      end
    endcase
  end

  always_comb begin
    fv_d = fv_q;
    if (accept) begin
      fv_d = 1'b1;
    end else if (fv_q && !cmd_full_i) begin
      fv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ===== src/mrp_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on mrp_pkg for the command type and queue sizing.
module mrp_queue
  import mrp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t head_o
);

  cmd_t              ent_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = ent_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== src/mrp_back.sv =====
// Back end: carries out commands, owns the pending HI16 stack and the
// result register. Depends on mrp_pkg.
module mrp_back
  import mrp_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = DEFAULT_PENDING_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        write_valid_o,
  output logic [31:0] write_address_o,
  output logic [31:0] write_data_o,
  output logic [1:0]  status_o,
  output logic        last_result_o
);

  localparam int unsigned IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);

  back_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] rd_idx, wr_idx;

  pend_t mem_q [PENDING_DEPTH];
  pend_t rd_q;
  logic  mem_we;

  logic [31:0] cur_sym_q, cur_sym_d;
  logic [31:0] cur_place_q, cur_place_d;
  logic [31:0] cur_word_q, cur_word_d;
  logic [31:0] addlo, lo_sum, hi_v;
  logic [15:0] hi_fix;

  logic        out_valid_q, out_valid_d;
  logic        out_wv_q, out_wv_d;
  logic [31:0] out_addr_q, out_addr_d;
  logic [31:0] out_data_q, out_data_d;
  status_e     out_st_q, out_st_d;
  logic        out_last_q, out_last_d;
  logic        out_free, out_load;

  assign cnt_m1   = count_q - CW'(1);
  assign rd_idx   = cnt_m1[IW-1:0];
  assign wr_idx   = count_q[IW-1:0];
  assign out_free = !out_valid_q || !out_stall_i;

  assign addlo  = {{16{cur_word_q[15]}}, cur_word_q[15:0]};
  assign lo_sum = cur_sym_q + addlo;
  assign hi_v   = {rd_q.word[15:0], 16'h0000} + addlo + cur_sym_q;
  assign hi_fix = hi_v[31:16] + {15'b0, hi_v[15]};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cur_sym_d   = cur_sym_q;
    cur_place_d = cur_place_q;
    cur_word_d  = cur_word_q;
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;
    out_load    = 1'b0;
    out_wv_d    = 1'b0;
    out_addr_d  = '0;
    out_data_d  = '0;
    out_st_d    = ST_OK;
    out_last_d  = 1'b1;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_EMIT: begin
              out_load   = 1'b1;
              out_wv_d   = cmd_i.wv;
              out_addr_d = cmd_i.place;
              out_data_d = cmd_i.word;
              out_st_d   = cmd_i.status;
            end
            OP_HI: begin
              out_load = 1'b1;
              if (count_q == CW'(PENDING_DEPTH)) begin
                out_st_d = ST_REJECT;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            OP_LO: begin
              cur_sym_d   = cmd_i.sym;
              cur_place_d = cmd_i.place;
              cur_word_d  = cmd_i.word;
              state_d     = (count_q == '0) ? BK_LO_FIN : BK_LO_RD;
            end
            default: begin
              out_load = 1'b1;
              out_st_d = ST_UNKNOWN;
            end
          endcase
        end
      end
      BK_LO_RD: begin
        state_d = BK_LO_EX;
      end
      BK_LO_EX: begin
        if (out_free) begin
          out_load = 1'b1;
          count_d  = cnt_m1;
          if (rd_q.sym != cur_sym_q) begin
            out_st_d = ST_REJECT;
            state_d  = BK_IDLE;
          end else begin
            out_wv_d   = 1'b1;
            out_addr_d = rd_q.place;
            out_data_d = {rd_q.word[31:16], hi_fix};
            out_last_d = 1'b0;
            state_d    = (cnt_m1 == '0) ? BK_LO_FIN : BK_LO_RD;
          end
        end
      end
      BK_LO_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_wv_d   = 1'b1;
          out_addr_d = cur_place_q;
          out_data_d = {cur_word_q[31:16], lo_sum[15:0]};
          count_d    = '0;
          state_d    = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_sym_q   <= cur_sym_d;
    cur_place_q <= cur_place_d;
    cur_word_q  <= cur_word_d;
    if (out_load) begin
      out_wv_q   <= out_wv_d;
      out_addr_q <= out_addr_d;
      out_data_q <= out_data_d;
      out_st_q   <= out_st_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx] <= '{sym: cmd_i.sym, place: cmd_i.place, word: cmd_i.word};
    end
    rd_q <= mem_q[rd_idx];
  end

  assign out_valid_o     = out_valid_q;
  assign write_valid_o   = out_wv_q;
  assign write_address_o = out_addr_q;
  assign write_data_o    = out_data_q;
  assign status_o        = out_st_q;
  assign last_result_o   = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(PENDING_DEPTH))
    else $error("pending count above stack depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (count_q < CW'(PENDING_DEPTH)))
    else $error("push into a full pending stack");

  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_LO_EX || state_q == BK_LO_RD) |-> (count_q != '0))
    else $error("LO16 walk with an empty pending stack");

  a_lo_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_LO_FIN && out_free) |=> (count_q == '0 && out_valid_q))
    else $error("LO16 completion did not clear the pending stack");

endmodule

// ===== src/mips_relocation_patcher.sv =====
// MIPS HI16/LO16 relocation patcher, top level. Depends on mrp_pkg and the
// front end, queue and back end modules.
// A simple item goes from the front-end register through a queue entry into the
// result register. Throughput: one item per cycle while out_stall_i is low, except
// LO16: the back end pops it, does a stack read and a result per pending entry,
// then the final LO16 result, or a reject result on a symbol mismatch.
// Reset: asynchronous, active low; clears the pending count, queue and valid flags.
// The pending stack contents are not cleared; no clearing pass is needed.
module mips_relocation_patcher
  import mrp_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = DEFAULT_PENDING_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  relocation_kind_i,
  input  logic        symbol_defined_i,
  input  logic [31:0] symbol_value_i,
  input  logic [31:0] place_address_i,
  input  logic [31:0] place_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        write_valid_o,
  output logic [31:0] write_address_o,
  output logic [31:0] write_data_o,
  output logic [1:0]  status_o,
  output logic        last_result_o
);

  logic fr_valid, q_full, q_valid, q_pop;
  cmd_t fr_cmd, q_head;

  mrp_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .relocation_kind_i (relocation_kind_i),
    .symbol_defined_i  (symbol_defined_i),
    .symbol_value_i    (symbol_value_i),
    .place_address_i   (place_address_i),
    .place_word_i      (place_word_i),
    .cmd_valid_o       (fr_valid),
    .cmd_full_i        (q_full),
    .cmd_o             (fr_cmd)
  );

  mrp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fr_valid),
    .push_cmd_i (fr_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .pop_i      (q_pop),
    .head_o     (q_head)
  );

  mrp_back #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_i           (q_head),
    .cmd_pop_o       (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .write_valid_o   (write_valid_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .status_o        (status_o),
    .last_result_o   (last_result_o)
  );

endmodule
